### design/tcf_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the tilt filter.
package tcf_pkg;

    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 56;
    localparam int CORDIC_MAX = 24;
    localparam int CNT_W      = 5;
    localparam int XY_W       = 20;
    localparam int Z_W        = 26;
    localparam int ACC_W      = 18;
    localparam int ATAN_W     = 21;
    localparam int DIV_Q_W    = 24;
    localparam int DIV_D_W    = 14;
    localparam int DIV_N_W    = 38;

    localparam logic signed [Z_W-1:0] PI_Q21      = 26'sd6588397;
    localparam logic signed [18:0]    PI_Q13      = 19'sd25736;
    localparam logic signed [18:0]    TWO_PI_Q13  = 19'sd51472;
    localparam logic signed [19:0]    RATE_K      = 20'sd285672;
    localparam logic signed [20:0]    RATE_MAX    = 21'sd163840;
    localparam logic signed [25:0]    TILT_MAX    = 26'sd8388352;
    localparam logic signed [25:0]    SMOOTH_MAX  = 26'sd2621440;
    localparam logic signed [15:0]    OFFSET_INIT = -16'sd123;
    localparam logic [DIV_D_W-1:0]    DIV_SMOOTH  = 14'd10;
    localparam logic [DIV_D_W-1:0]    DIV_FILT    = 14'd10000;
    localparam logic [DIV_N_W-1:0]    HALF_SMOOTH = 38'd5;
    localparam logic [DIV_N_W-1:0]    HALF_FILT   = 38'd5000;
    localparam logic [15:0]           MS_MIN      = 16'd2;
    localparam logic [15:0]           MS_MAX      = 16'd49;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_RATE,
        ST_SDIV,
        ST_SWAIT,
        ST_ANGLE,
        ST_FMUL,
        ST_FSUM,
        ST_FDIV,
        ST_FWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic rate;
        logic sdiv;
        logic s_upd;
        logic angle;
        logic fmul;
        logic fsum;
        logic fdiv;
        logic t_upd;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic div_done;
        logic div_busy;
        logic upd;
    } sts_t;

    // atan(2^-i) in 2^-21 rad
    function automatic logic [ATAN_W-1:0] atan_q21(input logic [CNT_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 21'd1647099;
            5'd1:    v = 21'd972340;
            5'd2:    v = 21'd513757;
            5'd3:    v = 21'd260791;
            5'd4:    v = 21'd130902;
            5'd5:    v = 21'd65515;
            5'd6:    v = 21'd32765;
            5'd7:    v = 21'd16384;
            5'd8:    v = 21'd8192;
            5'd9:    v = 21'd4096;
            5'd10:   v = 21'd2048;
            5'd11:   v = 21'd1024;
            5'd12:   v = 21'd512;
            5'd13:   v = 21'd256;
            5'd14:   v = 21'd128;
            5'd15:   v = 21'd64;
            5'd16:   v = 21'd32;
            5'd17:   v = 21'd16;
            5'd18:   v = 21'd8;
            5'd19:   v = 21'd4;
            5'd20:   v = 21'd2;
            5'd21:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

### design/tcf_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) rounded to 2^-13 rad.
module tcf_cordic import tcf_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [15:0]      y_in,
    input  logic signed [15:0]      x_in,
    output logic                    done,
    output logic signed [ACC_W-1:0] acc
);

    localparam int NSTEPS = (STEPS > CORDIC_MAX) ? CORDIC_MAX : STEPS;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NSTEPS - 1);

    logic signed [XY_W-1:0]  x_reg, x_next, y_reg, y_next, xs, ys, x_ext, y_ext;
    logic signed [Z_W-1:0]   z_reg, z_next, atan_z, z_pos, z_neg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next, rnd_reg, rnd_next, done_reg, done_next;
    logic                    zero_reg, zero_next, y_pos;

    always_comb begin
        x_ext  = XY_W'(x_in);
        y_ext  = XY_W'(y_in);
        xs     = x_reg >>> cnt_reg;
        ys     = y_reg >>> cnt_reg;
        y_pos  = !y_reg[XY_W-1] && (y_reg != '0);
        atan_z = signed'({{(Z_W-ATAN_W){1'b0}}, atan_q21(cnt_reg)});
        z_pos  = (z_reg + 26'sd128) >>> 8;
        z_neg  = -((-z_reg + 26'sd128) >>> 8);

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rnd_next  = 1'b0;
        done_next = done_reg;
        zero_next = zero_reg;
        acc_next  = acc_reg;

        if (start) begin
            zero_next = (x_in == '0) && (y_in == '0);
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            if (x_in[15]) begin
                x_next = -x_ext;
                y_next = -y_ext;
                z_next = y_in[15] ? -PI_Q21 : PI_Q21;
            end else begin
                x_next = x_ext;
                y_next = y_ext;
                z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_pos) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_z;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_z;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                rnd_next  = 1'b1;
            end
        end else if (rnd_reg) begin
            acc_next  = zero_reg ? '0 : ACC_W'(z_reg[Z_W-1] ? z_neg : z_pos);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

### design/tcf_divider.sv
// Constant divider for the rounding divides: reciprocal multiply, then a remainder fix-up.
module tcf_divider import tcf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic [DIV_Q_W-1:0] quotient
);

    // by 10: exact, ceil(2^27 / 10) on a dividend below 2^23
    // by 10000: floor(2^38 / 10000) on dividend[37:14], low by at most 3
    localparam logic [24:0] RECIP_SMOOTH = 25'd13421773;
    localparam logic [24:0] RECIP_FILT   = 25'd27487790;
    localparam int          SHIFT_SMOOTH = 3;
    localparam logic [2:0]  STG_PROD     = 3'd0;
    localparam logic [2:0]  STG_QEST     = 3'd1;
    localparam logic [2:0]  STG_REM      = 3'd2;
    localparam logic [2:0]  STG_LAST     = 3'd5;

    logic [DIV_N_W-1:0] n_reg, n_next, qd;
    logic [DIV_D_W-1:0] d_reg, d_next;
    logic [DIV_Q_W-1:0] q_reg, q_next, mul_a;
    logic [24:0]        mul_b, prod_reg, prod_next;
    logic [48:0]        mul_p;
    logic [15:0]        r_reg, r_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next, by_ten;

    always_comb begin
        by_ten = (d_reg == DIV_SMOOTH);
        mul_a  = by_ten ? n_reg[DIV_Q_W-1:0] : n_reg[DIV_N_W-1:DIV_N_W-DIV_Q_W];
        mul_b  = by_ten ? RECIP_SMOOTH : RECIP_FILT;
        mul_p  = 49'(mul_a) * 49'(mul_b);
        qd     = DIV_N_W'(q_reg) * DIV_N_W'(d_reg);

        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        prod_next = prod_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;

        if (start) begin
            n_next    = dividend;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            case (cnt_reg)
                STG_PROD: begin
                    prod_next = mul_p[48:24];
                end
                STG_QEST: begin
                    q_next = by_ten ? DIV_Q_W'(prod_reg >> SHIFT_SMOOTH)
                                    : prod_reg[DIV_Q_W-1:0];
                end
                STG_REM: begin
                    r_next = 16'(n_reg - qd);
                end
                default: begin
                    if (r_reg >= 16'(d_reg)) begin
                        q_next = q_reg + 1'b1;
                        r_next = r_reg - 16'(d_reg);
                    end
                end
            endcase
            if (cnt_reg == STG_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### design/tcf_datapath.sv
// Datapath: rate scaling, tilt wrap, low-pass and complementary filter state.
module tcf_datapath import tcf_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [S_DATA_W-1:0] in_tdata,
    input  logic                in_tuser,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    output logic [M_DATA_W-1:0] out_tdata,
    output logic                out_tuser
);

    logic signed [15:0]      gx_reg, bias_reg, off_reg, off_use;
    logic [15:0]             ms_reg;
    logic                    cal_reg, upd_reg, sneg_reg, fneg_reg, tuser_reg;
    logic signed [35:0]      prod_reg, prod_next, rnd_pos, rnd_neg, rnd;
    logic signed [20:0]      rdiff, rclamp;
    logic signed [18:0]      rate_reg, rate_next, adiff, awrap, angle_reg, angle_next;
    logic signed [18:0]      rsm_next;
    logic signed [23:0]      s_reg, s_next, s0_reg, s0_next, target, t_reg, t_next;
    logic signed [23:0]      tp, tn, sp, sn;
    logic signed [24:0]      sd;
    logic [24:0]             smag;
    logic signed [25:0]      qs, sq, ssum, sclamp, tq, tclamp;
    logic signed [ACC_W-1:0] acc;
    logic signed [38:0]      p1_reg, p1_next, p3_reg, p3_next, p2e, num_reg, num_next;
    logic signed [25:0]      p2_reg, p2_next;
    logic [38:0]             fmag;
    logic [DIV_N_W-1:0]      sdivd, fdivd, div_dividend;
    logic [DIV_D_W-1:0]      div_divisor;
    logic [DIV_Q_W-1:0]      div_q;
    logic signed [15:0]      tilt_next;
    logic [M_DATA_W-1:0]     tdata_reg, tdata_next;
    logic                    cordic_done, div_busy, div_done;

    tcf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load),
        .y_in    (in_tdata[15:0]),
        .x_in    (in_tdata[31:16]),
        .done    (cordic_done),
        .acc     (acc)
    );

    tcf_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sdiv || cmd.fdiv),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        // gyro counts to 2^-12 rad/s, round half away from zero
        prod_next = 36'(gx_reg) * 36'(RATE_K);
        rnd_pos   = (prod_reg + 36'sd32768) >>> 16;
        rnd_neg   = -((-prod_reg + 36'sd32768) >>> 16);
        rnd       = prod_reg[35] ? rnd_neg : rnd_pos;
        rdiff     = 21'(bias_reg) - 21'(rnd);
        if (rdiff > RATE_MAX) begin
            rclamp = RATE_MAX;
        end else if (rdiff < -RATE_MAX) begin
            rclamp = -RATE_MAX;
        end else begin
            rclamp = rdiff;
        end
        rate_next = 19'(rclamp);

        // low-pass, reloaded from the target when it sits at zero
        target  = 24'(rate_reg) <<< 4;
        s0_next = (s_reg == '0) ? target : s_reg;
        sd      = 25'(target) - 25'(s0_next);
        smag    = sd[24] ? 25'(-sd) : 25'(sd);
        sdivd   = DIV_N_W'(smag) + HALF_SMOOTH;
        qs      = signed'({2'b00, div_q});
        sq      = sneg_reg ? -qs : qs;
        ssum    = 26'(s0_reg) + sq;
        if (ssum > SMOOTH_MAX) begin
            sclamp = SMOOTH_MAX;
        end else if (ssum < -SMOOTH_MAX) begin
            sclamp = -SMOOTH_MAX;
        end else begin
            sclamp = ssum;
        end
        s_next = 24'(sclamp);

        // accel tilt relative to the zero offset, wrapped to +-pi
        off_use = cal_reg ? 16'(acc) : off_reg;
        adiff   = 19'(acc) - 19'(off_use);
        if (adiff > PI_Q13) begin
            awrap = adiff - TWO_PI_Q13;
        end else if (adiff < -PI_Q13) begin
            awrap = adiff + TWO_PI_Q13;
        end else begin
            awrap = adiff;
        end
        angle_next = -awrap;

        // t' = (9000*t + 4608*rate*ms + 256000*angle) / 10000
        p1_next  = 39'(t_reg) * 39'sd9000;
        p2_next  = 26'(rate_reg) * 26'(signed'({1'b0, ms_reg[5:0]}));
        p3_next  = 39'(angle_reg) * 39'sd256000;
        p2e      = 39'(p2_reg);
        num_next = p1_reg + (p2e <<< 12) + (p2e <<< 9) + p3_reg;
        fmag     = num_reg[38] ? 39'(-num_reg) : 39'(num_reg);
        fdivd    = DIV_N_W'(fmag) + HALF_FILT;
        tq       = fneg_reg ? -qs : qs;
        if (tq > TILT_MAX) begin
            tclamp = TILT_MAX;
        end else if (tq < -TILT_MAX) begin
            tclamp = -TILT_MAX;
        end else begin
            tclamp = tq;
        end
        t_next = 24'(tclamp);

        div_dividend = cmd.sdiv ? sdivd : fdivd;
        div_divisor  = cmd.sdiv ? DIV_SMOOTH : DIV_FILT;

        // output scaling
        tp         = (t_reg + 24'sd128) >>> 8;
        tn         = -((-t_reg + 24'sd128) >>> 8);
        tilt_next  = 16'(t_reg[23] ? tn : tp);
        sp         = (s_reg + 24'sd8) >>> 4;
        sn         = -((-s_reg + 24'sd8) >>> 4);
        rsm_next   = 19'(s_reg[23] ? sn : sp);
        tdata_next = {2'b00, rsm_next, rate_reg, tilt_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
            t_reg    <= '0;
            s_reg    <= '0;
            off_reg  <= OFFSET_INIT;
        end else begin
            if (cfg_wr_en) begin
                bias_reg <= cfg_wr_data;
            end
            if (cmd.t_upd) begin
                t_reg <= t_next;
            end
            if (cmd.s_upd) begin
                s_reg <= s_next;
            end
            if (cmd.angle && cal_reg) begin
                off_reg <= off_use;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gx_reg  <= in_tdata[47:32];
            ms_reg  <= in_tdata[63:48];
            cal_reg <= in_tuser;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.rate) begin
            rate_reg <= rate_next;
        end
        if (cmd.sdiv) begin
            s0_reg   <= s0_next;
            sneg_reg <= sd[24];
        end
        if (cmd.angle) begin
            angle_reg <= angle_next;
            upd_reg   <= sts.upd;
        end
        if (cmd.fmul) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
        if (cmd.fsum) begin
            num_reg <= num_next;
        end
        if (cmd.fdiv) begin
            fneg_reg <= num_reg[38];
        end
        if (cmd.publish) begin
            tdata_reg <= tdata_next;
            tuser_reg <= upd_reg;
        end
    end

    assign sts.cordic_done = cordic_done;
    assign sts.div_done    = div_done;
    assign sts.div_busy    = div_busy;
    assign sts.upd         = (ms_reg >= MS_MIN) && (ms_reg <= MS_MAX);
    assign out_tdata       = tdata_reg;
    assign out_tuser       = tuser_reg;

endmodule

### design/tcf_ctrl.sv
// Controller: sequences one sample through the datapath and holds the output beat.
module tcf_ctrl import tcf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_RATE;
            end
            ST_RATE: begin
                cmd.rate   = 1'b1;
                state_next = ST_SDIV;
            end
            ST_SDIV: begin
                cmd.sdiv   = 1'b1;
                state_next = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (sts.div_done && sts.cordic_done) begin
                    cmd.s_upd  = 1'b1;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                cmd.angle  = 1'b1;
                state_next = sts.upd ? ST_FMUL : ST_DONE;
            end
            ST_FMUL: begin
                cmd.fmul   = 1'b1;
                state_next = ST_FSUM;
            end
            ST_FSUM: begin
                cmd.fsum   = 1'b1;
                state_next = ST_FDIV;
            end
            ST_FDIV: begin
                cmd.fdiv   = 1'b1;
                state_next = ST_FWAIT;
            end
            ST_FWAIT: begin
                if (sts.div_done) begin
                    cmd.t_upd  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sdiv || cmd.fdiv) |-> !sts.div_busy)
        else $error("divider started while busy");

    a_pub_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_valid_reg)
        else $error("published beat not presented");

    a_angle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ANGLE) |-> sts.cordic_done)
        else $error("tilt used before CORDIC finished");

    a_cordic_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !sts.cordic_done)
        else $error("CORDIC done flag not cleared on new beat");

endmodule

### design/tilt_complementary_filter.sv
// Top level of the tilt complementary filter.
//
// Input beat (s_axis): one IMU sample with accel Y/Z, gyro X and the elapsed
// time in ms; s_axis_tuser set makes the current accel tilt the new zero.
// Output beat (m_axis): filtered tilt, bias-corrected body rate, smoothed rate,
// and in m_axis_tuser whether the complementary filter advanced.
// cfg_wr_en/cfg_wr_data load the gyro bias; write it only while idle.
// One sample is processed at a time. The tilt update runs only when the elapsed
// time is within 2..49 ms and adds a constant divide after the CORDIC and the
// smoothing divide; the next beat is taken once the result is published.
// A finished beat sits in the output register: a stalled receiver does
// not stop the next sample from being accepted and processed, only its publish.
// Reset clears the filter state, bias and output valid; zero offset resets
// to -123 (2^-13 rad).
module tilt_complementary_filter import tcf_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // accel_y_raw, accel_z_raw, gyro_x_raw, elapsed_ms
    input  logic                s_axis_tuser,  // calibrate
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // tilt_angle, gyro_rate, rate_smoothed, 2'b0
    output logic                m_axis_tuser,  // filter_updated
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    tcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcf_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_tdata    (s_axis_tdata),
        .in_tuser    (s_axis_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_tdata   (m_axis_tdata),
        .out_tuser   (m_axis_tuser)
    );

endmodule

### bench/testbench.sv
// Self-checking testbench for tilt_complementary_filter: directed and random IMU beats checked against a predictor.
`timescale 1ns / 100ps

module testbench import tcf_pkg::*;;

    localparam int     STEPS      = 16;
    localparam longint PI_FINE    = 6588397;
    localparam longint PI_COARSE  = 25736;
    localparam longint TWO_PI     = 51472;
    localparam longint GYRO_SCALE = 285672;
    localparam longint RATE_SAT   = 163840;
    localparam longint TILT_SAT   = 8388352;
    localparam longint SMOOTH_SAT = 2621440;
    localparam int     LIMIT      = 400000;
    localparam int     HOLD_LEN   = 600;

    typedef struct packed {
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [15:0] gyro_x;
        logic [15:0] elapsed;
        logic        cal;
    } imu_sample_t;

    typedef struct packed {
        logic [15:0] tilt;
        logic [18:0] rate;
        logic [18:0] smooth;
        logic        updated;
    } tilt_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_wr_en     = 1'b0;
    logic [15:0]         cfg_wr_data   = '0;

    imu_sample_t  sample_queue[$];
    tilt_result_t predicted_outputs[$];

    longint atan_step [24] = '{1647099, 972340, 513757, 260791, 130902, 65515, 32765,
                               16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
                               32, 16, 8, 4, 2, 1, 0, 0};

    longint gyro_bias_q   = 0;
    longint tilt_state    = 0;
    longint smooth_state  = 0;
    longint zero_off      = -123;

    int  mismatches = 0;
    int  cycles     = 0;
    int  idle_pct   = 10;
    int  send_gap   = 0;
    int  recv_gap   = 0;
    bit  s_fire     = 1'b0;
    bit  hold_go    = 1'b0;
    bit  rx_hold_on = 1'b0;

    tilt_complementary_filter #(.CORDIC_STEPS(STEPS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic longint rnd_shift(longint v, int s);
        longint half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint rnd_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // vectoring CORDIC, result in 2^-13 rad
    function automatic longint accel_tilt(longint y, longint x);
        longint z = 0;
        longint xs, ys;
        int     i;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_FINE : -PI_FINE;
            x = -x;
            y = -y;
        end
        for (i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step[i];
            end
        end
        return rnd_shift(z, 8);
    endfunction

    function automatic tilt_result_t advance_filter(logic [S_DATA_W-1:0] data, logic cal);
        longint       ay, az, gx, ms, acc, diff, angle, rate, target, num;
        logic         upd;
        tilt_result_t r;
        ay = longint'($signed(data[15:0]));
        az = longint'($signed(data[31:16]));
        gx = longint'($signed(data[47:32]));
        ms = longint'(data[63:48]);
        acc = accel_tilt(ay, az);
        if (cal) zero_off = acc;
        diff = acc - zero_off;
        if (diff > PI_COARSE) diff = diff - TWO_PI;
        else if (diff < -PI_COARSE) diff = diff + TWO_PI;
        angle = -diff;
        rate = sat(gyro_bias_q - rnd_shift(gx * GYRO_SCALE, 16), RATE_SAT);
        upd = (ms >= 2 && ms <= 49);
        if (upd) begin
            num = 9 * (tilt_state * 1000 + rate * ms * 512) + angle * 256000;
            tilt_state = sat(rnd_div(num, 10000), TILT_SAT);
        end
        target = rate * 16;
        if (smooth_state == 0) smooth_state = target;
        smooth_state = sat(smooth_state + rnd_div(target - smooth_state, 10), SMOOTH_SAT);
        r.tilt    = 16'(sat(rnd_shift(tilt_state, 8), 32767));
        r.rate    = 19'(rate);
        r.smooth  = 19'(sat(rnd_shift(smooth_state, 4), RATE_SAT));
        r.updated = upd;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [18:0] got, logic [18:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic queue_sample(logic [15:0] ay, logic [15:0] az, logic [15:0] gx,
                                logic [15:0] ms, logic cal);
        imu_sample_t smp;
        smp.accel_y = ay;
        smp.accel_z = az;
        smp.gyro_x  = gx;
        smp.elapsed = ms;
        smp.cal     = cal;
        sample_queue.push_back(smp);
    endtask

    task automatic queue_random(int count);
        int          n, mode, pick;
        logic [15:0] ay, az, gx, ms;
        logic [15:0] corners [5];
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        for (n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
                // near-level body, gravity mostly on Z
                ay = 16'($urandom_range(0, 12000) - 6000);
                az = 16'(16384 + $urandom_range(0, 6000) - 3000);
            end else if (mode < 7) begin
                ay = 16'($urandom);
                az = 16'($urandom);
            end else if (mode == 7) begin
                ay = 16'h0000;
                az = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
            end else if (mode == 8) begin
                ay = 16'($urandom);
                az = 16'h0000;
            end else begin
                ay = corners[$urandom_range(0, 4)];
                az = corners[$urandom_range(0, 4)];
            end
            pick = $urandom_range(0, 9);
            if (pick < 3) gx = 16'($urandom);
            else if (pick < 8) gx = 16'($urandom_range(0, 600) - 300);
            else if (pick == 8) gx = 16'($urandom_range(0, 6) - 3);
            else gx = 16'h0000;
            pick = $urandom_range(0, 19);
            if (pick < 15) ms = 16'($urandom_range(2, 49));
            else if (pick == 15) ms = 16'($urandom_range(0, 1));
            else if (pick == 16) ms = 16'd50;
            else ms = 16'($urandom);
            queue_sample(ay, az, gx, ms, $urandom_range(0, 29) == 0);
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (sample_queue.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0);
    endtask

    task automatic write_bias(logic [15:0] value);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sender
    always @(negedge aclk) begin
        imu_sample_t smp;
        if (aresetn && (!s_axis_tvalid || s_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                smp = sample_queue.pop_front();
                s_axis_tdata  <= {smp.elapsed, smp.gyro_x, smp.accel_z, smp.accel_y};
                s_axis_tuser  <= smp.cal;
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 15);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn || rx_hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct) recv_gap = $urandom_range(1, 15);
        end
    end

    // long receiver stall so the output register and the input back up
    initial begin
        wait (hold_go);
        rx_hold_on = 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        rx_hold_on = 1'b0;
    end

    // predictor and checker
    always @(posedge aclk) begin
        tilt_result_t want;
        s_fire = 1'b0;
        if (aresetn) begin
            if (cfg_wr_en) gyro_bias_q = longint'($signed(cfg_wr_data));
            if (s_axis_tvalid && s_axis_tready) begin
                s_fire = 1'b1;
                predicted_outputs.push_back(advance_filter(s_axis_tdata, s_axis_tuser));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch("output beat with nothing pending");
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("tilt_angle", 19'(m_axis_tdata[15:0]), 19'(want.tilt));
                    check_field("gyro_rate", m_axis_tdata[34:16], want.rate);
                    check_field("rate_smoothed", m_axis_tdata[53:35], want.smooth);
                    check_field("filter_updated", 19'(m_axis_tuser), 19'(want.updated));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          ph;
        logic [15:0] bias;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_bias(16'h0000);
        // directed: zero accel, tilt at pi, calibration, corners, time window edges
        queue_sample(16'h0000, 16'h0000, 16'h0000, 16'd10, 1'b0);
        queue_sample(16'h0000, 16'hFC18, 16'd100, 16'd10, 1'b0);
        queue_sample(16'd1000, 16'd16000, 16'h0000, 16'd5, 1'b1);
        queue_sample(16'd1200, 16'd16000, 16'd20, 16'd5, 1'b0);
        queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd2, 1'b0);
        queue_sample(16'h8000, 16'h8000, 16'h8000, 16'd49, 1'b0);
        queue_sample(16'h8000, 16'h0000, 16'h7FFF, 16'd0, 1'b0);
        queue_sample(16'h7FFF, 16'h8000, 16'h8000, 16'd1, 1'b0);
        queue_sample(16'h0001, 16'h8000, 16'h0001, 16'd50, 1'b0);
        queue_sample(16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_sample(16'h0000, 16'h7FFF, 16'h0000, 16'd49, 1'b1);
        queue_sample(16'h0000, 16'h8000, 16'h0000, 16'd2, 1'b1);
        queue_sample(16'h0000, 16'h0000, 16'h0000, 16'd20, 1'b0);
        queue_sample(16'd3000, 16'd15000, 16'd2, 16'd10, 1'b0);
        queue_sample(16'd3000, 16'd15000, 16'hFFFE, 16'd10, 1'b0);
        queue_sample(16'h8000, 16'h7FFF, 16'd0, 16'd3, 1'b0);
        queue_sample(16'h7FFF, 16'h0000, 16'd0, 16'd48, 1'b1);
        queue_sample(16'h8000, 16'h0001, 16'd0, 16'd30, 1'b0);
        queue_sample(16'd500, 16'd16384, 16'd0, 16'd51, 1'b0);
        queue_sample(16'd500, 16'd16384, 16'd0, 16'h8000, 1'b0);
        wait_idle();

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       bias = 16'h7FFF;
                1:       bias = 16'h8000;
                3, 5:    bias = 16'($urandom_range(0, 1600) - 800);
                default: bias = 16'($urandom);
            endcase
            write_bias(bias);
            case (ph)
                1, 4:    idle_pct = 0;
                2:       idle_pct = 25;
                5:       idle_pct = 35;
                6:       idle_pct = 0;
                default: idle_pct = 12;
            endcase
            if (ph == 2) hold_go = 1'b1;
            queue_random(120);
            wait_idle();
        end

        repeat (80) @(posedge aclk);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

### tilt_complementary_filter.f
design/tcf_pkg.sv
design/tcf_cordic.sv
design/tcf_divider.sv
design/tcf_datapath.sv
design/tcf_ctrl.sv
design/tilt_complementary_filter.sv
bench/testbench.sv
